// ===== hdl/sha_pkg.sv =====
// shared constants, types and helper functions for the byte stream sha-256 hasher
// no dependencies; imported by every module of the block
package sha_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] SRC_IN   = 2'd0;
  localparam logic [1:0] SRC_MARK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       push;
    logic [1:0] src;
    logic       count;
    logic       start;
    logic       round;
    logic       fold;
    logic       clear;
    logic [2:0] sel;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
  } sha_sts_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_s0(input word_t x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/sha_dp.sv =====
// datapath: byte gathering, schedule window, round variables and hash value
// depends on sha_pkg; driven by sha_ctrl through sha_cmd_t
module sha_dp import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sha_cmd_t   cmd,
  input  logic [7:0] in_byte,
  output sha_sts_t   sts,
  output word_t      digest
);

  logic [23:0] acc_r;
  word_t       win_r [16];
  word_t       hash_r [8];
  word_t       v_r [8];
  logic [5:0]  fill_r;
  logic [60:0] total_r;
  logic [5:0]  rnd_r;

  logic [63:0] bits;
  logic [7:0]  len_byte;
  logic [7:0]  byte_sel;
  word_t       word_in;
  word_t       w_sched;
  word_t       w_cur;
  word_t       t1;
  word_t       t2;

  assign bits     = {total_r, 3'b000};
  assign len_byte = bits[6'(63 - 8 * fill_r[2:0]) -: 8];

  always_comb begin
    case (cmd.src)
      SRC_IN:   byte_sel = in_byte;
      SRC_MARK: byte_sel = PAD_MARK;
      SRC_LEN:  byte_sel = len_byte;
      default:  byte_sel = 8'h00;
    endcase
  end

  assign word_in = {acc_r, byte_sel};
  assign w_sched = win_r[0] + small_s0(win_r[1]) + win_r[9] + small_s1(win_r[14]);
  assign w_cur   = (rnd_r < 6'd16) ? win_r[0] : w_sched;
  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + w_cur;
  assign t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign sts.fill     = fill_r;
  assign sts.rnd_last = (rnd_r == 6'd63);
  assign digest       = hash_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
      rnd_r   <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_H[i];
    end else begin
      if (cmd.push) begin
        fill_r <= fill_r + 6'd1;
        acc_r  <= {acc_r[15:0], byte_sel};
        if (fill_r[1:0] == 2'd3) begin
          for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
          win_r[15] <= word_in;
        end
      end
      if (cmd.count) total_r <= total_r + 61'd1;
      if (cmd.start) begin
        rnd_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
      end
      if (cmd.round) begin
        rnd_r <= rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
        win_r[15] <= w_cur;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
      if (cmd.clear) begin
        fill_r  <= '0;
        total_r <= '0;
        for (int i = 0; i < 8; i++) hash_r[i] <= INIT_H[i];
      end
    end
  end

endmodule

// ===== hdl/sha_ctrl.sv =====
// controller: input handshake, padding sequence, round sequencing and digest output
// depends on sha_pkg; steers sha_dp through sha_cmd_t
module sha_ctrl import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_idx,
  input  sha_sts_t   sts,
  output sha_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] after_r, after_nxt;
  logic       first_r, first_nxt;
  logic       lenok_r, lenok_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       full;
  logic       final_byte;

  assign full       = (sts.fill == FILL_LAST);
  assign final_byte = !first_r && lenok_r && full;
  assign out_idx    = idx_r;

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    first_nxt = first_r;
    lenok_nxt = lenok_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.sel   = idx_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_kind)
            KIND_DATA, KIND_LAST: begin
              cmd.push  = 1'b1;
              cmd.src   = SRC_IN;
              cmd.count = 1'b1;
              after_nxt = (in_kind == KIND_LAST) ? S_PAD : S_IDLE;
              if (in_kind == KIND_LAST) begin
                first_nxt = 1'b1;
                lenok_nxt = 1'b0;
                state_nxt = S_PAD;
              end
              if (full) begin
                cmd.start = 1'b1;
                state_nxt = S_ROUND;
              end
            end
            KIND_END: begin
              first_nxt = 1'b1;
              lenok_nxt = 1'b0;
              state_nxt = S_PAD;
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (first_r) cmd.src = SRC_MARK;
        else if (lenok_r && sts.fill >= LEN_START) cmd.src = SRC_LEN;
        else cmd.src = SRC_ZERO;
        if (first_r) begin
          first_nxt = 1'b0;
          if (sts.fill < LEN_START) lenok_nxt = 1'b1;
        end
        if (full) begin
          cmd.start = 1'b1;
          state_nxt = S_ROUND;
          after_nxt = final_byte ? S_OUT : S_PAD;
          if (!final_byte) lenok_nxt = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.rnd_last) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = after_r;
        idx_nxt   = '0;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      first_r <= 1'b0;
      lenok_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      first_r <= first_nxt;
      lenok_r <= lenok_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// sha-256 hasher fed one message byte per item: top level joining controller and datapath
// depends on sha_pkg, sha_ctrl and sha_dp
//
// usage
// - input channel: in_message_byte and in_kind, valid/stall handshake. kind 0 is a data
//   byte, kind 1 the final data byte, kind 2 ends the message without a byte, kind 3 is
//   taken and ignored
// - result channel: eight items per message, out_digest_word with out_word_index 0..7,
//   out_last_word high on the eighth
// - a data byte is taken straight into the block; the 64th byte of a block starts the
//   rounds and then the fold, all in the single-round compression unit
// - message end: padding bytes go through the same byte path one a cycle while no
//   compression runs (up to 72 when the length spills into an extra block), with one
//   or two compressions (rounds, then fold), then the digest items follow
// - in_stall stays high during compression, padding and digest output; one item at a time
// - while the receiver stalls, the current digest item holds and nothing advances
// - after the last digest item the hash value, byte count and fill return to their
//   initial state and the next message may start
// - reset (synchronous, active low) loads the initial hash values and clears counts;
//   no clearing pass is needed
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic [1:0]  in_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // command and status between the two halves
  sha_cmd_t cmd;
  sha_sts_t sts;
  word_t    digest;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_idx   (out_word_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_message_byte),
    .sts     (sts),
    .digest  (digest)
  );

  assign out_digest_word = digest;
  assign out_last_word   = (out_word_index == 3'd7);

  // no new item is taken while a digest is being delivered
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted during digest output");

  // the last digest item closes the output sequence
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !out_valid)
    else $error("output continues after last word");

  // digest words advance by one per delivered item
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest index skipped");

endmodule
